### hw/rtl/rsr_pkg.sv
// Shared types and constants for the row span rasterizer.
// Used by rsr_front, rsr_queue, rsr_back and the top level; depends on nothing.
package rsr_pkg;

  typedef enum logic [2:0] {
    OP_CLEAR  = 3'd0,
    OP_HLINE  = 3'd1,
    OP_VLINE  = 3'd2,
    OP_RECT   = 3'd3,
    OP_CIRCLE = 3'd4
  } op_t;

  // Span items carry a finished first/last pair, circle items need the root.
  typedef enum logic {
    KIND_SPAN = 1'b0,
    KIND_CIRC = 1'b1
  } kind_t;

  typedef struct packed {
    logic  vld;
    kind_t kind;
  } item_ctl_t;

  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_ROW_STRIDE   = 2'd2;

  localparam int FIELD_W   = 16;
  localparam int ROW_W     = 12;
  localparam int RAD_W     = 14;
  localparam int COLOR_W   = 24;
  localparam int ADDR_W    = 28;
  localparam int FRAME_W   = 13;
  localparam int STRIDE_W  = 16;
  localparam int SQ_IN_W   = 2 * RAD_W;
  localparam int SQ_STEPS  = RAD_W;
  localparam int SQ_REM_W  = RAD_W + 1;

  localparam logic [FRAME_W-1:0] FRAME_MAX = 13'd4096;
  localparam int BYTES_PER_PIXEL = 3;
  localparam int QUEUE_DEPTH     = 4;

  // Internal signed coordinate width: room for coordinate plus or minus a radius.
  function automatic int coord_iw(input int cb);
    return ((cb > 15) ? cb : 15) + 2;
  endfunction

  // Queue entry: row, two coordinates, radius, colour.
  function automatic int pay_w(input int iw);
    return ROW_W + 2 * iw + RAD_W + COLOR_W;
  endfunction

endpackage

### hw/rtl/rsr_front.sv
// Front end: accepts a draw command and classifies it for one scan row.
// Drops rows the command misses; depends on rsr_pkg.
module rsr_front #(
  parameter int COORD_BITS = 16
) (
  input  logic                               start,
  input  logic                               busy,
  input  logic [2:0]                         in_op,
  input  logic [7:0]                         in_color_red,
  input  logic [7:0]                         in_color_green,
  input  logic [7:0]                         in_color_blue,
  input  logic [rsr_pkg::FIELD_W-1:0]        in_scan_row,
  input  logic [rsr_pkg::FIELD_W-1:0]        in_x_a,
  input  logic [rsr_pkg::FIELD_W-1:0]        in_y_a,
  input  logic [rsr_pkg::FIELD_W-1:0]        in_x_b,
  input  logic [rsr_pkg::FIELD_W-1:0]        in_y_b,
  input  logic [7:0]                         in_thickness,
  input  logic [rsr_pkg::RAD_W-1:0]          in_radius,
  input  logic [rsr_pkg::FRAME_W-1:0]        w_sat,
  input  logic [rsr_pkg::FRAME_W-1:0]        h_sat,
  output rsr_pkg::item_ctl_t                 push,
  output logic [rsr_pkg::pay_w(rsr_pkg::coord_iw(COORD_BITS))-1:0] push_pay
);
  import rsr_pkg::*;

  localparam int IW       = coord_iw(COORD_BITS);
  localparam int LOW_BITS = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
  localparam bit SIGN_EXT = (COORD_BITS <= FIELD_W);

  function automatic logic signed [IW-1:0] coord(input logic [FIELD_W-1:0] v);
    logic [IW-1:0] ext;
    ext = '0;
    for (int i = 0; i < LOW_BITS; i++) ext[i] = v[i];
    for (int i = LOW_BITS; i < IW; i++) ext[i] = SIGN_EXT & v[LOW_BITS-1];
    return signed'(ext);
  endfunction

  logic signed [IW-1:0] row, xa, ya, xb, yb, half, rad, dy, lo, hi;
  logic                 hit, row_ok;
  kind_t                kind;

  always_comb begin
    row  = coord(in_scan_row);
    xa   = coord(in_x_a);
    ya   = coord(in_y_a);
    xb   = coord(in_x_b);
    yb   = coord(in_y_b);
    half = signed'(IW'(in_thickness[7:1]));
    rad  = signed'(IW'(in_radius));
    dy   = row - ya;
    hit  = 1'b0;
    kind = KIND_SPAN;
    lo   = xa;
    hi   = xb;
    case (op_t'(in_op))
      OP_CLEAR: begin
        hit = 1'b1;
        lo  = '0;
        hi  = signed'(IW'(w_sat) - IW'(1));
      end
      OP_HLINE: begin
        hit = (row >= ya - half) && (row <= ya + half);
      end
      OP_VLINE: begin
        hit = (row >= ya) && (row <= yb);
        lo  = xa - half;
        hi  = xa + half;
      end
      OP_RECT: begin
        hit = (row >= ya) && (row <= yb);
      end
      OP_CIRCLE: begin
        // rows cy-r .. cy+r-1; carry |dy| in place of the last column
        hit  = (dy >= -rad) && (dy < rad);
        kind = KIND_CIRC;
        hi   = dy[IW-1] ? -dy : dy;
      end
      default: begin
        hit = 1'b0;
      end
    endcase
    row_ok    = (row >= 0) && (row < signed'(IW'(h_sat)));
    push.vld  = start && !busy && hit && row_ok;
    push.kind = kind;
    push_pay  = {row[ROW_W-1:0], lo, hi, in_radius,
                 in_color_blue, in_color_green, in_color_red};
  end

endmodule

### hw/rtl/rsr_queue.sv
// Short queue between the front end and the back end.
// Holds classified items; depends on rsr_pkg.
module rsr_queue #(
  parameter int WIDTH = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rsr_pkg::item_ctl_t push,
  input  logic [WIDTH-1:0]   push_pay,
  output logic               full,
  output rsr_pkg::item_ctl_t head,
  output logic [WIDTH-1:0]   head_pay
);
  import rsr_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  kind_t            mem_kind [QUEUE_DEPTH];
  logic [WIDTH-1:0] mem_pay  [QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             pop;

  // The back end takes the head entry every cycle it is present.
  always_comb begin
    pop       = (count_r != '0);
    full      = (count_r == CNT_W'(QUEUE_DEPTH));
    head.vld  = pop;
    head.kind = mem_kind[rptr_r];
    head_pay  = mem_pay[rptr_r];
    wptr_nxt  = push.vld ? PTR_W'(wptr_r + 1'b1) : wptr_r;
    rptr_nxt  = pop ? PTR_W'(rptr_r + 1'b1) : rptr_r;
    count_nxt = CNT_W'(count_r + CNT_W'(push.vld) - CNT_W'(pop));
  end

  always_ff @(posedge clk) begin
    if (push.vld) begin
      mem_kind[wptr_r] <= push.kind;
      mem_pay[wptr_r]  <= push_pay;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

### hw/rtl/rsr_back.sv
// Back end: circle half-width by pipelined square root, clip, address.
// One item per clock through a fixed-length pipeline; depends on rsr_pkg.
module rsr_back #(
  parameter int COORD_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  rsr_pkg::item_ctl_t                 head,
  input  logic [rsr_pkg::pay_w(rsr_pkg::coord_iw(COORD_BITS))-1:0] head_pay,
  input  logic [rsr_pkg::FRAME_W-1:0]        w_sat,
  input  logic [rsr_pkg::STRIDE_W-1:0]       row_stride,
  output logic                               out_valid,
  output logic [rsr_pkg::ROW_W-1:0]          out_span_row,
  output logic [rsr_pkg::ROW_W-1:0]          out_span_x_first,
  output logic [rsr_pkg::ROW_W-1:0]          out_span_x_last,
  output logic [rsr_pkg::ADDR_W-1:0]         out_span_address,
  output logic [7:0]                         out_blue,
  output logic [7:0]                         out_green,
  output logic [7:0]                         out_red
);
  import rsr_pkg::*;

  localparam int IW      = coord_iw(COORD_BITS);
  localparam int PW      = pay_w(IW);
  localparam int RAD_LSB = COLOR_W;
  localparam int B_LSB   = RAD_LSB + RAD_W;
  localparam int A_LSB   = B_LSB + IW;
  localparam int ROW_LSB = A_LSB + IW;

  // ---- multiply stage: r*r and dy*dy
  item_ctl_t            m_ctl_r;
  logic [PW-1:0]        m_pay_r;
  logic [SQ_IN_W-1:0]   m_rr_r, m_dd_r;
  logic [RAD_W-1:0]     h_rad, h_dmag;

  assign h_rad  = head_pay[RAD_LSB +: RAD_W];
  assign h_dmag = head_pay[B_LSB +: RAD_W];

  always_ff @(posedge clk) begin
    m_pay_r <= head_pay;
    m_rr_r  <= SQ_IN_W'(h_rad) * SQ_IN_W'(h_rad);
    m_dd_r  <= SQ_IN_W'(h_dmag) * SQ_IN_W'(h_dmag);
    if (!rst_n) m_ctl_r <= '0;
    else        m_ctl_r <= head;
  end

  // ---- square root pipeline, one root bit per stage
  item_ctl_t            sq_ctl_r  [SQ_STEPS+1];
  logic [PW-1:0]        sq_pay_r  [SQ_STEPS+1];
  logic [SQ_REM_W-1:0]  sq_rem_r  [SQ_STEPS+1];
  logic [RAD_W-1:0]     sq_root_r [SQ_STEPS+1];
  logic [SQ_IN_W-1:0]   sq_n_r    [SQ_STEPS];

  always_ff @(posedge clk) begin
    sq_pay_r[0]  <= m_pay_r;
    sq_n_r[0]    <= m_rr_r - m_dd_r;
    sq_rem_r[0]  <= '0;
    sq_root_r[0] <= '0;
    if (!rst_n) sq_ctl_r[0] <= '0;
    else        sq_ctl_r[0] <= m_ctl_r;
  end

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
    logic [SQ_REM_W+1:0] rem2, trial;
    logic                ge;
    logic [SQ_REM_W-1:0] rem_nxt;
    logic [RAD_W-1:0]    root_nxt;

    always_comb begin
      rem2     = {sq_rem_r[k], sq_n_r[k][SQ_IN_W-1 -: 2]};
      trial    = {1'b0, sq_root_r[k], 2'b01};
      ge       = (rem2 >= trial);
      rem_nxt  = ge ? SQ_REM_W'(rem2 - trial) : SQ_REM_W'(rem2);
      root_nxt = {sq_root_r[k][RAD_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      sq_pay_r[k+1]  <= sq_pay_r[k];
      sq_rem_r[k+1]  <= rem_nxt;
      sq_root_r[k+1] <= root_nxt;
      if (!rst_n) sq_ctl_r[k+1] <= '0;
      else        sq_ctl_r[k+1] <= sq_ctl_r[k];
    end

    if (k < SQ_STEPS - 1) begin : g_shift
      always_ff @(posedge clk) begin
        sq_n_r[k+1] <= {sq_n_r[k][SQ_IN_W-3:0], 2'b00};
      end
    end
  end

  // ---- round and form the run
  logic                 r_vld_r;
  logic signed [IW-1:0] r_lo_r, r_hi_r;
  logic [ROW_W-1:0]     r_row_r;
  logic [COLOR_W-1:0]   r_col_r;
  logic [RAD_W-1:0]     s_root;
  logic [SQ_REM_W-1:0]  s_rem;
  logic signed [IW-1:0] dx, s_a, s_b, lo_nxt, hi_nxt;
  logic [PW-1:0]        s_pay;

  always_comb begin
    s_pay  = sq_pay_r[SQ_STEPS];
    s_root = sq_root_r[SQ_STEPS];
    s_rem  = sq_rem_r[SQ_STEPS];
    s_a    = signed'(s_pay[A_LSB +: IW]);
    s_b    = signed'(s_pay[B_LSB +: IW]);
    // round half up: bump when the remainder exceeds the root
    dx     = signed'(IW'(s_root) + IW'(s_rem > SQ_REM_W'(s_root)));
    if (sq_ctl_r[SQ_STEPS].kind == KIND_CIRC) begin
      lo_nxt = s_a - dx;
      hi_nxt = s_a + dx - signed'(IW'(1));
    end else begin
      lo_nxt = s_a;
      hi_nxt = s_b;
    end
  end

  always_ff @(posedge clk) begin
    r_lo_r  <= lo_nxt;
    r_hi_r  <= hi_nxt;
    r_row_r <= s_pay[ROW_LSB +: ROW_W];
    r_col_r <= s_pay[COLOR_W-1:0];
    if (!rst_n) r_vld_r <= 1'b0;
    else        r_vld_r <= sq_ctl_r[SQ_STEPS].vld;
  end

  // ---- clip to the frame width, drop empty runs
  logic                 c_vld_r, c_vld_nxt;
  logic [ROW_W-1:0]     c_lo_r, c_hi_r, c_row_r;
  logic [COLOR_W-1:0]   c_col_r;
  logic signed [IW-1:0] w_last, lo_c, hi_c;

  always_comb begin
    w_last    = signed'(IW'(w_sat) - IW'(1));
    lo_c      = (r_lo_r < 0) ? '0 : r_lo_r;
    hi_c      = (r_hi_r > w_last) ? w_last : r_hi_r;
    c_vld_nxt = r_vld_r && (lo_c <= hi_c);
  end

  always_ff @(posedge clk) begin
    c_lo_r  <= lo_c[ROW_W-1:0];
    c_hi_r  <= hi_c[ROW_W-1:0];
    c_row_r <= r_row_r;
    c_col_r <= r_col_r;
    if (!rst_n) c_vld_r <= 1'b0;
    else        c_vld_r <= c_vld_nxt;
  end

  // ---- byte offset and output register
  logic                out_valid_r;
  logic [ROW_W-1:0]    out_row_r, out_first_r, out_last_r;
  logic [ADDR_W-1:0]   out_addr_r, addr_nxt;
  logic [COLOR_W-1:0]  out_col_r;

  assign addr_nxt = ADDR_W'(c_row_r) * ADDR_W'(row_stride)
                  + ADDR_W'(c_lo_r) * ADDR_W'(BYTES_PER_PIXEL);

  always_ff @(posedge clk) begin
    out_row_r   <= c_row_r;
    out_first_r <= c_lo_r;
    out_last_r  <= c_hi_r;
    out_addr_r  <= addr_nxt;
    out_col_r   <= c_col_r;
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= c_vld_r;
  end

  assign out_valid        = out_valid_r;
  assign out_span_row     = out_row_r;
  assign out_span_x_first = out_first_r;
  assign out_span_x_last  = out_last_r;
  assign out_span_address = out_addr_r;
  assign out_blue         = out_col_r[23:16];
  assign out_green        = out_col_r[15:8];
  assign out_red          = out_col_r[7:0];

endmodule

### hw/rtl/shape_row_span_rasterizer_top.sv
// Top level of the row span rasterizer: config registers and the
// front end / queue / back end chain. Depends on rsr_pkg, rsr_front, rsr_queue, rsr_back.
//
//   channel   ports                                   handshake
//   -------   -------------------------------------   -------------------------------
//   input     in_op .. in_radius                      beat taken when start && !busy
//   result    out_span_* , out_blue/green/red         one-cycle beat marked by out_valid
//   config    psel penable pwrite paddr pwdata prdata write on psel&&penable&&pwrite
//
// One command beat per clock. A beat that yields a run goes through the queue,
// multiply, 14-stage square root, round, clip and output registers to out_valid.
// Reset is synchronous, active low; registers return to 640 x 480, stride 1920.
// busy rises only when the four-entry queue is full; the back end drains one entry
// every clock, so busy stays low. Results cannot be held off by the receiver.
module shape_row_span_rasterizer_top #(
  parameter int COORD_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // command channel
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_op,
  input  logic [7:0]  in_color_red,
  input  logic [7:0]  in_color_green,
  input  logic [7:0]  in_color_blue,
  input  logic [15:0] in_scan_row,
  input  logic [15:0] in_x_a,
  input  logic [15:0] in_y_a,
  input  logic [15:0] in_x_b,
  input  logic [15:0] in_y_b,
  input  logic [7:0]  in_thickness,
  input  logic [13:0] in_radius,
  // result channel
  output logic        out_valid,
  output logic [11:0] out_span_row,
  output logic [11:0] out_span_x_first,
  output logic [11:0] out_span_x_last,
  output logic [27:0] out_span_address,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_green,
  output logic [7:0]  out_red,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rsr_pkg::*;

  localparam int IW = coord_iw(COORD_BITS);
  localparam int PW = pay_w(IW);

  // ---- configuration registers
  logic [FRAME_W-1:0]  fw_r, fw_nxt, fh_r, fh_nxt, w_sat, h_sat;
  logic [STRIDE_W-1:0] stride_r, stride_nxt;
  logic                wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    fw_nxt     = fw_r;
    fh_nxt     = fh_r;
    stride_nxt = stride_r;
    if (wr_en) begin
      case (paddr[3:2])
        REG_FRAME_WIDTH:  fw_nxt     = pwdata[FRAME_W-1:0];
        REG_FRAME_HEIGHT: fh_nxt     = pwdata[FRAME_W-1:0];
        REG_ROW_STRIDE:   stride_nxt = pwdata[STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_FRAME_WIDTH:  prdata = 32'(fw_r);
      REG_FRAME_HEIGHT: prdata = 32'(fh_r);
      REG_ROW_STRIDE:   prdata = 32'(stride_r);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r     <= 13'd640;
      fh_r     <= 13'd480;
      stride_r <= 16'd1920;
    end else begin
      fw_r     <= fw_nxt;
      fh_r     <= fh_nxt;
      stride_r <= stride_nxt;
    end
  end

  // Clip limits saturate at the largest frame.
  assign w_sat = (fw_r > FRAME_MAX) ? FRAME_MAX : fw_r;
  assign h_sat = (fh_r > FRAME_MAX) ? FRAME_MAX : fh_r;

  // ---- front end: take the beat, drop missed rows, classify
  item_ctl_t     q_push, q_head;
  logic [PW-1:0] q_push_pay, q_head_pay;
  logic          q_full;

  assign busy = q_full;

  rsr_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .start          (start),
    .busy           (q_full),
    .in_op          (in_op),
    .in_color_red   (in_color_red),
    .in_color_green (in_color_green),
    .in_color_blue  (in_color_blue),
    .in_scan_row    (in_scan_row),
    .in_x_a         (in_x_a),
    .in_y_a         (in_y_a),
    .in_x_b         (in_x_b),
    .in_y_b         (in_y_b),
    .in_thickness   (in_thickness),
    .in_radius      (in_radius),
    .w_sat          (w_sat),
    .h_sat          (h_sat),
    .push           (q_push),
    .push_pay       (q_push_pay)
  );

  // ---- queue: decouple front and back
  rsr_queue #(
    .WIDTH (PW)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_pay (q_push_pay),
    .full     (q_full),
    .head     (q_head),
    .head_pay (q_head_pay)
  );

  // ---- back end: root, clip, address, output register
  rsr_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (q_head),
    .head_pay         (q_head_pay),
    .w_sat            (w_sat),
    .row_stride       (stride_r),
    .out_valid        (out_valid),
    .out_span_row     (out_span_row),
    .out_span_x_first (out_span_x_first),
    .out_span_x_last  (out_span_x_last),
    .out_span_address (out_span_address),
    .out_blue         (out_blue),
    .out_green        (out_green),
    .out_red          (out_red)
  );

  // ---- checks
  a_run_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_span_x_first <= out_span_x_last))
    else $error("emitted run has first column after last column");

  a_run_in_width: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, out_span_x_last} < w_sat))
    else $error("emitted run extends past the frame width");

  a_row_in_height: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, out_span_row} < h_sat))
    else $error("emitted row lies outside the frame height");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    q_push.vld |-> !q_full)
    else $error("queue written while full");

endmodule

### verif/tb_shape_row_span_rasterizer_top.sv
// Self-checking testbench for shape_row_span_rasterizer_top: drives draw commands,
// predicts each clipped row run in the bench and checks every result beat.
// Depends on rsr_pkg and the RTL of the rasterizer; reads no files.
module tb_shape_row_span_rasterizer_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rsr_pkg::*;

  // Drains wait out the result latency of the block, padded.
  localparam int SPAN_LATENCY = 19;
  localparam int DRAIN_CYCLES = SPAN_LATENCY + 8;
  localparam int QUIET_LIMIT  = 2000;

  typedef struct {
    logic [2:0]         op;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic signed [15:0] scan_row;
    logic signed [15:0] x_a;
    logic signed [15:0] y_a;
    logic signed [15:0] x_b;
    logic signed [15:0] y_b;
    logic [7:0]         thickness;
    logic [13:0]        radius;
  } draw_cmd_t;

  typedef struct {
    logic [11:0] row;
    logic [11:0] x_first;
    logic [11:0] x_last;
    logic [27:0] address;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
  } row_run_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  in_op = '0;
  logic [7:0]  in_color_red = '0;
  logic [7:0]  in_color_green = '0;
  logic [7:0]  in_color_blue = '0;
  logic [15:0] in_scan_row = '0;
  logic [15:0] in_x_a = '0;
  logic [15:0] in_y_a = '0;
  logic [15:0] in_x_b = '0;
  logic [15:0] in_y_b = '0;
  logic [7:0]  in_thickness = '0;
  logic [13:0] in_radius = '0;

  logic        out_valid;
  logic [11:0] out_span_row;
  logic [11:0] out_span_x_first;
  logic [11:0] out_span_x_last;
  logic [27:0] out_span_address;
  logic [7:0]  out_blue;
  logic [7:0]  out_green;
  logic [7:0]  out_red;

  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Bench copy of the frame registers; only changed while the block is idle.
  logic [12:0] frame_w_now = 13'd640;
  logic [12:0] frame_h_now = 13'd480;
  logic [15:0] stride_now = 16'd1920;

  draw_cmd_t cmd_backlog[$];
  draw_cmd_t cmd_on_pins;
  row_run_t  runs_due[$];

  int gap_pct = 10;
  int fail_count = 0;
  int cmds_taken = 0;
  int runs_checked = 0;
  int frame_settings = 1;
  int quiet_cycles = 0;

  shape_row_span_rasterizer_top u_top (
    .clk(clk), .rst_n(rst_n),
    .start(start), .busy(busy),
    .in_op(in_op), .in_color_red(in_color_red), .in_color_green(in_color_green),
    .in_color_blue(in_color_blue), .in_scan_row(in_scan_row), .in_x_a(in_x_a),
    .in_y_a(in_y_a), .in_x_b(in_x_b), .in_y_b(in_y_b), .in_thickness(in_thickness),
    .in_radius(in_radius),
    .out_valid(out_valid), .out_span_row(out_span_row),
    .out_span_x_first(out_span_x_first), .out_span_x_last(out_span_x_last),
    .out_span_address(out_span_address), .out_blue(out_blue), .out_green(out_green),
    .out_red(out_red),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Nearest-integer square root, found by bisection over the radius range.
  function automatic longint round_root(input longint n);
    longint lo_s;
    longint hi_s;
    longint mid;
    lo_s = 0;
    hi_s = 16384;
    while (lo_s < hi_s) begin
      mid = (lo_s + hi_s + 1) / 2;
      if (mid * mid <= n) lo_s = mid;
      else hi_s = mid - 1;
    end
    return (n - lo_s * lo_s > lo_s) ? lo_s + 1 : lo_s;
  endfunction

  // Work out the clipped run a command covers on its scan row; 0 when empty.
  function automatic bit predict_row_run(input draw_cmd_t c, output row_run_t run);
    longint row;
    longint xa;
    longint ya;
    longint xb;
    longint yb;
    longint half;
    longint rad;
    longint wid;
    longint hgt;
    longint lo;
    longint hi;
    longint dy;
    longint dx;
    longint addr;
    row  = c.scan_row;
    xa   = c.x_a;
    ya   = c.y_a;
    xb   = c.x_b;
    yb   = c.y_b;
    half = c.thickness >> 1;
    rad  = c.radius;
    wid  = (frame_w_now > 13'd4096) ? 4096 : frame_w_now;
    hgt  = (frame_h_now > 13'd4096) ? 4096 : frame_h_now;
    run  = '{default: '0};
    case (c.op)
      OP_CLEAR: begin
        lo = 0;
        hi = wid - 1;
      end
      OP_HLINE: begin
        if (row < ya - half || row > ya + half) return 0;
        lo = xa;
        hi = xb;
      end
      OP_VLINE: begin
        if (row < ya || row > yb) return 0;
        lo = xa - half;
        hi = xa + half;
      end
      OP_RECT: begin
        if (row < ya || row > yb) return 0;
        lo = xa;
        hi = xb;
      end
      OP_CIRCLE: begin
        // circle spans rows cy-r .. cy+r-1, half-width rounded from the exact root
        dy = row - ya;
        if (dy < -rad || dy >= rad) return 0;
        dx = round_root(rad * rad - dy * dy);
        lo = xa - dx;
        hi = xa + dx - 1;
      end
      default: return 0;
    endcase
    if (row < 0 || row >= hgt) return 0;
    if (lo < 0) lo = 0;
    if (hi > wid - 1) hi = wid - 1;
    if (lo > hi) return 0;
    addr        = lo * 3 + row * stride_now;
    run.row     = row[11:0];
    run.x_first = lo[11:0];
    run.x_last  = hi[11:0];
    run.address = addr[27:0];
    run.blue    = c.blue;
    run.green   = c.green;
    run.red     = c.red;
    return 1;
  endfunction

  // Command driver: count the beat taken at this edge, then hold, advance or idle.
  always @(posedge clk) begin : drive_cmds
    row_run_t run;
    bit       go;
    if (rst_n && start && !busy) begin
      cmds_taken++;
      if (predict_row_run(cmd_on_pins, run)) runs_due.push_back(run);
    end
    if (!rst_n) begin
      go = 1'b0;
    end else if (start && busy) begin
      go = 1'b1;  // hold the same beat until the block takes it
    end else if (cmd_backlog.size() != 0 && $urandom_range(99) >= gap_pct) begin
      cmd_on_pins = cmd_backlog.pop_front();
      in_op          <= cmd_on_pins.op;
      in_color_red   <= cmd_on_pins.red;
      in_color_green <= cmd_on_pins.green;
      in_color_blue  <= cmd_on_pins.blue;
      in_scan_row    <= cmd_on_pins.scan_row;
      in_x_a         <= cmd_on_pins.x_a;
      in_y_a         <= cmd_on_pins.y_a;
      in_x_b         <= cmd_on_pins.x_b;
      in_y_b         <= cmd_on_pins.y_b;
      in_thickness   <= cmd_on_pins.thickness;
      in_radius      <= cmd_on_pins.radius;
      go = 1'b1;
    end else begin
      go = 1'b0;
    end
    start <= go;
  end

  task automatic check_field(input string name, input longint exp_v, input longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // Result monitor: every strobed beat must match the oldest predicted run.
  always @(posedge clk) begin : watch_runs
    row_run_t want;
    if (rst_n && out_valid) begin
      if (runs_due.size() == 0) begin
        $error("run beat with nothing pending: row %0d x %0d..%0d",
               out_span_row, out_span_x_first, out_span_x_last);
        fail_count++;
      end else begin
        want = runs_due.pop_front();
        check_field("span_row", want.row, out_span_row);
        check_field("span_x_first", want.x_first, out_span_x_first);
        check_field("span_x_last", want.x_last, out_span_x_last);
        check_field("span_address", want.address, out_span_address);
        check_field("out_blue", want.blue, out_blue);
        check_field("out_green", want.green, out_green);
        check_field("out_red", want.red, out_red);
        runs_checked++;
      end
    end
  end

  // Watchdog: end the run once nothing has moved on any port for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d runs still due",
               QUIET_LIMIT, runs_due.size());
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One register access: setup cycle, then access until pready.
  task automatic reg_access(input logic [1:0] idx, input bit is_write,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Read all three registers back against the bench copy.
  task automatic check_regs();
    logic [31:0] rd;
    reg_access(REG_FRAME_WIDTH, 1'b0, '0, rd);
    check_field("frame_width", frame_w_now, rd);
    reg_access(REG_FRAME_HEIGHT, 1'b0, '0, rd);
    check_field("frame_height", frame_h_now, rd);
    reg_access(REG_ROW_STRIDE, 1'b0, '0, rd);
    check_field("row_stride", stride_now, rd);
  endtask

  task automatic program_frame(input int wid, input int hgt, input int stride);
    logic [31:0] rd;
    reg_access(REG_FRAME_WIDTH, 1'b1, wid, rd);
    reg_access(REG_FRAME_HEIGHT, 1'b1, hgt, rd);
    reg_access(REG_ROW_STRIDE, 1'b1, stride, rd);
    frame_w_now = wid[12:0];
    frame_h_now = hgt[12:0];
    stride_now  = stride[15:0];
    frame_settings++;
    check_regs();
  endtask

  // Coordinate mostly around the visible range, sometimes anywhere in 16 bits.
  function automatic int near_coord(input int lim);
    if ($urandom_range(99) < 80) return int'($urandom_range(lim + 128)) - 64;
    return $urandom_range(16'hFFFF);
  endfunction

  function automatic draw_cmd_t make_cmd(input int op, input int row, input int xa,
                                         input int ya, input int xb, input int yb,
                                         input int thick, input int rad);
    draw_cmd_t c;
    c.op        = op[2:0];
    c.red       = $urandom;
    c.green     = $urandom;
    c.blue      = $urandom;
    c.scan_row  = row[15:0];
    c.x_a       = xa[15:0];
    c.y_a       = ya[15:0];
    c.x_b       = xb[15:0];
    c.y_b       = yb[15:0];
    c.thickness = thick[7:0];
    c.radius    = rad[13:0];
    return c;
  endfunction

  // Mostly well-formed shapes that touch the asked row; the rest is noise.
  function automatic draw_cmd_t random_cmd();
    int wid;
    int hgt;
    int row;
    int half;
    int rad;
    int op;
    int xa;
    int ya;
    int xb;
    int yb;
    int sel;
    wid = (frame_w_now > 13'd4096) ? 4096 : frame_w_now;
    hgt = (frame_h_now > 13'd4096) ? 4096 : frame_h_now;
    op  = ($urandom_range(99) < 8) ? $urandom_range(7, 5) : $urandom_range(4, 0);
    row = near_coord(hgt);
    half = $urandom_range(255);
    sel = $urandom_range(99);
    if (sel < 60) rad = $urandom_range(300);
    else if (sel < 90) rad = $urandom_range(4096);
    else rad = $urandom_range(16383);
    xa = near_coord(wid);
    xb = ($urandom_range(3) == 0) ? near_coord(wid) : xa + int'($urandom_range(wid));
    ya = near_coord(hgt);
    yb = near_coord(hgt);
    if (op == OP_HLINE && $urandom_range(99) < 75) begin
      ya = row + int'($urandom_range((half >> 1) * 2 + 4)) - (half >> 1) - 2;
    end else if ((op == OP_VLINE || op == OP_RECT) && $urandom_range(99) < 75) begin
      ya = row - int'($urandom_range(40));
      yb = row + int'($urandom_range(40));
    end else if (op == OP_CIRCLE && $urandom_range(99) < 75) begin
      ya = row + int'($urandom_range(2 * rad + 2)) - rad - 1;
    end
    return make_cmd(op, row, xa, ya, xb, yb, half, rad);
  endfunction

  // Let the backlog drain, then wait out every pending run plus the pipeline.
  task automatic drain_all();
    while (cmd_backlog.size() != 0 || start) @(posedge clk);
    while (runs_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_phase(input int count, input int pct);
    gap_pct = pct;
    repeat (count) cmd_backlog.push_back(random_cmd());
    drain_all();
    gap_pct = 10;
  endtask

  task automatic load_directed();
    draw_cmd_t c;
    // clear on first and last rows, both colour extremes
    c = make_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0);
    c.red = 8'h00; c.green = 8'h00; c.blue = 8'h00;
    cmd_backlog.push_back(c);
    c = make_cmd(OP_CLEAR, 479, 0, 0, 0, 0, 0, 0);
    c.red = 8'hFF; c.green = 8'hFF; c.blue = 8'hFF;
    cmd_backlog.push_back(c);
    // rows just outside the frame
    cmd_backlog.push_back(make_cmd(OP_CLEAR, 480, 0, 0, 0, 0, 0, 0));
    cmd_backlog.push_back(make_cmd(OP_CLEAR, -1, 0, 0, 0, 0, 0, 0));
    // thickest horizontal line over the full coordinate range, at and past its edge
    cmd_backlog.push_back(make_cmd(OP_HLINE, 100, -32768, 100, 32767, 0, 255, 0));
    cmd_backlog.push_back(make_cmd(OP_HLINE, 227, -32768, 100, 32767, 0, 255, 0));
    cmd_backlog.push_back(make_cmd(OP_HLINE, 228, -32768, 100, 32767, 0, 255, 0));
    // reversed x bounds
    cmd_backlog.push_back(make_cmd(OP_HLINE, 10, 50, 10, 10, 0, 3, 0));
    // vertical lines: zero thickness, clipped at the right, reversed y
    cmd_backlog.push_back(make_cmd(OP_VLINE, 10, 0, 5, 0, 20, 0, 0));
    cmd_backlog.push_back(make_cmd(OP_VLINE, 10, 639, 5, 0, 20, 7, 0));
    cmd_backlog.push_back(make_cmd(OP_VLINE, 10, 100, 20, 0, 5, 9, 0));
    // rectangles: clipped both sides, fully right of the frame
    cmd_backlog.push_back(make_cmd(OP_RECT, 0, -5, 0, 700, 0, 0, 0));
    cmd_backlog.push_back(make_cmd(OP_RECT, 3, 640, 0, 700, 9, 0, 0));
    // circles: zero radius, top row with zero half-width, top+1, last row, row past
    cmd_backlog.push_back(make_cmd(OP_CIRCLE, 50, 100, 50, 0, 0, 0, 0));
    cmd_backlog.push_back(make_cmd(OP_CIRCLE, 40, 100, 50, 0, 0, 0, 10));
    cmd_backlog.push_back(make_cmd(OP_CIRCLE, 41, 100, 50, 0, 0, 0, 10));
    cmd_backlog.push_back(make_cmd(OP_CIRCLE, 59, 100, 50, 0, 0, 0, 10));
    cmd_backlog.push_back(make_cmd(OP_CIRCLE, 60, 100, 50, 0, 0, 0, 10));
    // largest radius: near the top pole, and through the centre
    cmd_backlog.push_back(make_cmd(OP_CIRCLE, 1, 300, 16383, 0, 0, 0, 16383));
    cmd_backlog.push_back(make_cmd(OP_CIRCLE, 200, 320, 200, 0, 0, 0, 16383));
    // unknown operations
    cmd_backlog.push_back(make_cmd(5, 10, 0, 10, 600, 20, 8, 5));
    cmd_backlog.push_back(make_cmd(6, 10, 0, 10, 600, 20, 8, 5));
    cmd_backlog.push_back(make_cmd(7, 10, 0, 10, 600, 20, 8, 5));
    // extreme scan rows
    cmd_backlog.push_back(make_cmd(OP_CLEAR, 32767, 0, 0, 0, 0, 0, 0));
    cmd_backlog.push_back(make_cmd(OP_HLINE, -32768, 0, -32768, 600, 0, 255, 0));
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values first, then the directed shapes on the default frame.
    check_regs();
    load_directed();
    drain_all();
    random_phase(250, 10);

    // Largest frame and stride with the sender never idling.
    program_frame(4096, 4096, 65535);
    random_phase(300, 0);

    program_frame(1, 1, 3);
    random_phase(150, 10);

    // Size registers past 4096 saturate the clip; stride of zero.
    program_frame(8191, 8191, 0);
    random_phase(250, 10);

    // Zero width, then zero height: nothing may come out.
    program_frame(0, 480, 1920);
    random_phase(100, 10);
    program_frame(640, 0, 1920);
    random_phase(100, 10);

    repeat (3) begin
      program_frame($urandom_range(4096, 1), $urandom_range(4096, 1),
                    $urandom_range(65535, 3));
      random_phase(250, 10);
    end

    program_frame(640, 480, 1920);
    random_phase(250, 10);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (runs_due.size() != 0) begin
      $error("%0d predicted runs never arrived", runs_due.size());
      fail_count++;
    end

    $display("Ran %0d draw commands over %0d frame settings; %0d row runs compared.",
             cmds_taken, frame_settings, runs_checked);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
